### hdl/hsvc_pkg.sv
// Package for the HSV to RGB converter: word types, field widths, defaults
// and the hue sector codes. No dependencies.
`default_nettype none

package hsvc_pkg;

  // Field widths of the words on both channels.
  localparam int unsigned HUE_W      = 16;
  localparam int unsigned CHAN_IN_W  = 12;
  localparam int unsigned CHAN_OUT_W = 11;

  // Defaults for the top-level parameters.
  localparam int unsigned CHANNEL_FRAC_BITS_DEF = 10;
  localparam int unsigned HUE_FRAC_BITS_DEF     = 6;

  // Degrees in one turn and in one sector of the color wheel.
  localparam int unsigned DEG_TURN   = 360;
  localparam int unsigned DEG_SECTOR = 60;

  typedef struct packed {
    logic signed [HUE_W-1:0]     hue;
    logic signed [CHAN_IN_W-1:0] saturation;
    logic signed [CHAN_IN_W-1:0] brightness;
    logic signed [CHAN_IN_W-1:0] alpha_in;
  } hsvc_in_t;

  typedef struct packed {
    logic [CHAN_OUT_W-1:0] red;
    logic [CHAN_OUT_W-1:0] green;
    logic [CHAN_OUT_W-1:0] blue;
    logic [CHAN_OUT_W-1:0] alpha_out;
  } hsvc_out_t;

  // Advance enables for the two register stages of a constant divider.
  typedef struct packed {
    logic mul_en;
    logic fix_en;
  } hsvc_en_t;

  // Sixty-degree sectors of the hue wheel, named by the color span they cover.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hsvc_sector_e;

endpackage

`default_nettype wire

### hdl/hsvc_cdiv.sv
// Two-stage divider by a constant: reciprocal multiply, then one correction.
// Depends on hsvc_pkg for the stage enable struct.
`default_nettype none

module hsvc_cdiv
  import hsvc_pkg::*;
#(
  parameter int unsigned WIDTH   = 18,
  parameter int unsigned DIVISOR = 23040,
  parameter int unsigned QUOT_W  = 2,
  parameter int unsigned REM_W   = 15
) (
  input  logic              clk_i,
  input  hsvc_en_t          en_i,
  input  logic [WIDTH-1:0]  dividend_i,
  output logic [QUOT_W-1:0] quot_o,
  output logic [REM_W-1:0]  rem_o
);

  // With SH >= WIDTH the estimate is the true quotient or one less.
  localparam int unsigned SH    = WIDTH + $clog2(DIVISOR);
  localparam int unsigned RW    = WIDTH + 2;
  localparam int unsigned PRODW = WIDTH + RW;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / 64'(DIVISOR));

  logic [PRODW-1:0]  prod;
  logic [WIDTH-1:0]  dvd_q;
  logic [QUOT_W-1:0] qest_q;
  logic [WIDTH-1:0]  diff;
  logic              over;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W-1:0]  rem_q;

  assign prod = PRODW'(dividend_i) * PRODW'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      dvd_q  <= dividend_i;
      qest_q <= QUOT_W'(prod >> SH);
    end
  end

  assign diff = dvd_q - WIDTH'(qest_q * DIVISOR);
  assign over = (diff >= WIDTH'(DIVISOR));

  always_ff @(posedge clk_i) begin
    if (en_i.fix_en) begin
      quot_q <= qest_q + QUOT_W'(over);
      rem_q  <= over ? REM_W'(diff - WIDTH'(DIVISOR)) : REM_W'(diff);
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

### hdl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: an eight-stage pixel pipeline.
// Depends on hsvc_pkg and hsvc_cdiv.
//
//   channel   direction  handshake               word
//   in        sink       in_valid_i / in_stall_o   hsvc_in_t  (hue, s, v, alpha)
//   out       source     out_valid_o / out_stall_i hsvc_out_t (r, g, b, alpha)
//
// One word enters per cycle while in_stall_o is low and travels to the output register
// (eight stages): clamp, two for the hue divide by one turn, sector, chroma product, two for
// the divide by 60, and placement. Reset clears only the stage valid bits; no clearing pass.
// Each stage holds while the next one is full and stalled, so bubbles close up
// and the input keeps accepting words while the output waits, until every stage is full.
`default_nettype none

module hsv_to_rgb_converter
  import hsvc_pkg::*;
#(
  parameter int unsigned CHANNEL_FRAC_BITS = CHANNEL_FRAC_BITS_DEF,
  parameter int unsigned HUE_FRAC_BITS     = HUE_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  hsvc_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output hsvc_out_t out_data_o
);

  localparam int unsigned NSTG   = 8;
  localparam int unsigned ONE    = 1 << CHANNEL_FRAC_BITS;
  localparam int unsigned INMAX  = (1 << (CHAN_IN_W - 1)) - 1;
  localparam int unsigned CMAX   = (ONE < INMAX) ? ONE : INMAX;
  localparam int unsigned CW     = $clog2(CMAX + 1);
  localparam int unsigned TURN   = DEG_TURN << HUE_FRAC_BITS;
  localparam int unsigned SECT   = DEG_SECTOR << HUE_FRAC_BITS;
  localparam int unsigned NSEC   = DEG_TURN / DEG_SECTOR;
  localparam int unsigned HSPAN  = 1 << HUE_W;
  localparam int unsigned HOFF   = (TURN - ((HSPAN / 2) % TURN)) % TURN;
  localparam int unsigned WW     = $clog2(HSPAN + TURN);
  localparam int unsigned HQMAX  = ((1 << WW) - 1) / TURN;
  localparam int unsigned HQW    = $clog2(HQMAX + 1);
  localparam int unsigned HRW    = $clog2(TURN);
  localparam int unsigned SRW    = $clog2(SECT);
  localparam int unsigned NW     = $clog2(SECT + 1);
  localparam int unsigned PW     = $clog2(CMAX * DEG_SECTOR + 1);
  localparam int unsigned XQMAX  = ((1 << PW) - 1) / DEG_SECTOR;
  localparam int unsigned XQW    = $clog2(XQMAX + 1);
  localparam int unsigned XRW    = $clog2(DEG_SECTOR);

  function automatic logic [CW-1:0] clamp_unit(input logic signed [CHAN_IN_W-1:0] x);
    logic [CW-1:0] r;
    if (x <= 0) begin
      r = '0;
    end else if (int'(x) >= int'(ONE)) begin
      r = CW'(ONE);
    end else begin
      r = CW'(x);
    end
    return r;
  endfunction

  // Stage control.
  logic [NSTG-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_d = ({vld_q[NSTG-2:0], in_valid_i} & rdy) | (vld_q & ~rdy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NSTG-1];

  // Stage 0: clamp the channels and bias the hue to a non-negative value that
  // is congruent to it modulo one turn.
  logic [CW-1:0] s0_s_q, s0_v_q, s0_a_q;
  logic [WW-1:0] s0_w_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s0_s_q <= clamp_unit(in_data_i.saturation);
      s0_v_q <= clamp_unit(in_data_i.brightness);
      s0_a_q <= clamp_unit(in_data_i.alpha_in);
      s0_w_q <= WW'({~in_data_i.hue[HUE_W-1], in_data_i.hue[HUE_W-2:0]}) + WW'(HOFF);
    end
  end

  // Stages 1 and 2: hue modulo one turn in the divider; chroma alongside.
  hsvc_en_t        hue_en;
  logic [HRW-1:0]  hue_rem;
  logic [2*CW-1:0] vs_prod;
  logic [CW-1:0]   s1_c_q, s1_v_q, s1_a_q;
  logic [CW-1:0]   s2_c_q, s2_m_q, s2_a_q;

  assign hue_en = '{mul_en: rdy[1], fix_en: rdy[2]};

  hsvc_cdiv #(
    .WIDTH   (WW),
    .DIVISOR (TURN),
    .QUOT_W  (HQW),
    .REM_W   (HRW)
  ) u_hue_div (
    .clk_i      (clk_i),
    .en_i       (hue_en),
    .dividend_i (s0_w_q),
    .quot_o     (),
    .rem_o      (hue_rem)
  );

  assign vs_prod = s0_v_q * s0_s_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_c_q <= CW'(vs_prod >> CHANNEL_FRAC_BITS);
      s1_v_q <= s0_v_q;
      s1_a_q <= s0_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      s2_c_q <= s1_c_q;
      s2_m_q <= s1_v_q - s1_c_q;
      s2_a_q <= s1_a_q;
    end
  end

  // Stage 3: sector and the distance into it, mirrored in odd sectors.
  logic [2:0]     sec_cnt;
  logic [HRW-1:0] sec_base;
  logic [SRW-1:0] sec_rem;
  logic [NW-1:0]  sec_num;
  hsvc_sector_e   s3_sec_q;
  logic [NW-1:0]  s3_num_q;
  logic [CW-1:0]  s3_c_q, s3_m_q, s3_a_q;

  always_comb begin
    sec_cnt = '0;
    for (int k = 1; k < NSEC; k++) begin
      if (32'(hue_rem) >= k * SECT) begin
        sec_cnt = sec_cnt + 3'd1;
      end
    end
  end

  assign sec_base = HRW'(32'(sec_cnt) * SECT);
  assign sec_rem  = SRW'(hue_rem - sec_base);
  assign sec_num  = sec_cnt[0] ? NW'(SECT) - NW'(sec_rem) : NW'(sec_rem);

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      s3_sec_q <= hsvc_sector_e'(sec_cnt);
      s3_num_q <= sec_num;
      s3_c_q   <= s2_c_q;
      s3_m_q   <= s2_m_q;
      s3_a_q   <= s2_a_q;
    end
  end

  // Stage 4: chroma times the sector distance. Dropping the hue fraction bits
  // first leaves a plain divide by 60 for the next two stages.
  logic [CW+NW-1:0] cn_prod;
  logic [PW-1:0]    s4_pd_q;
  hsvc_sector_e     s4_sec_q;
  logic [CW-1:0]    s4_c_q, s4_m_q, s4_a_q;

  assign cn_prod = s3_c_q * s3_num_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      s4_pd_q  <= PW'(cn_prod >> HUE_FRAC_BITS);
      s4_sec_q <= s3_sec_q;
      s4_c_q   <= s3_c_q;
      s4_m_q   <= s3_m_q;
      s4_a_q   <= s3_a_q;
    end
  end

  // Stages 5 and 6: the intermediate component X in the divider.
  hsvc_en_t       x_en;
  logic [XQW-1:0] x_quot;
  hsvc_sector_e   s5_sec_q, s6_sec_q;
  logic [CW-1:0]  s5_c_q, s5_m_q, s5_a_q;
  logic [CW-1:0]  s6_c_q, s6_m_q, s6_a_q;

  assign x_en = '{mul_en: rdy[5], fix_en: rdy[6]};

  hsvc_cdiv #(
    .WIDTH   (PW),
    .DIVISOR (DEG_SECTOR),
    .QUOT_W  (XQW),
    .REM_W   (XRW)
  ) u_x_div (
    .clk_i      (clk_i),
    .en_i       (x_en),
    .dividend_i (s4_pd_q),
    .quot_o     (x_quot),
    .rem_o      ()
  );

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      s5_sec_q <= s4_sec_q;
      s5_c_q   <= s4_c_q;
      s5_m_q   <= s4_m_q;
      s5_a_q   <= s4_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      s6_sec_q <= s5_sec_q;
      s6_c_q   <= s5_c_q;
      s6_m_q   <= s5_m_q;
      s6_a_q   <= s5_a_q;
    end
  end

  // Stage 7: place C and X by sector and add m. Grey and black need no special
  // path: zero saturation gives C = X = 0 and m = v, zero value gives all zero.
  logic [CW-1:0] x_val, r_sel, g_sel, b_sel;
  hsvc_out_t     out_d, out_q;

  assign x_val = CW'(x_quot);

  always_comb begin
    case (s6_sec_q)
      SEC_RED_YEL: begin r_sel = s6_c_q; g_sel = x_val;  b_sel = '0;     end
      SEC_YEL_GRN: begin r_sel = x_val;  g_sel = s6_c_q; b_sel = '0;     end
      SEC_GRN_CYN: begin r_sel = '0;     g_sel = s6_c_q; b_sel = x_val;  end
      SEC_CYN_BLU: begin r_sel = '0;     g_sel = x_val;  b_sel = s6_c_q; end
      SEC_BLU_MAG: begin r_sel = x_val;  g_sel = '0;     b_sel = s6_c_q; end
      default:     begin r_sel = s6_c_q; g_sel = '0;     b_sel = x_val;  end
    endcase
  end

  always_comb begin
    out_d.red       = CHAN_OUT_W'(r_sel + s6_m_q);
    out_d.green     = CHAN_OUT_W'(g_sel + s6_m_q);
    out_d.blue      = CHAN_OUT_W'(b_sel + s6_m_q);
    out_d.alpha_out = CHAN_OUT_W'(s6_a_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[7]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&vld_q))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_fills_stage0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted word did not reach the first stage");

  a_hue_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (32'(hue_rem) < TURN))
    else $error("wrapped hue is not below one turn");

  a_out_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.red) <= CMAX && 32'(out_data_o.green) <= CMAX &&
                     32'(out_data_o.blue) <= CMAX && 32'(out_data_o.alpha_out) <= CMAX))
    else $error("output channel above full scale");
`endif

endmodule

`default_nettype wire
